// ===== rtl/ptst_pkg.sv =====
// Package for the periodic timer slot table: item types, request and status codes,
// and the command and status structs that join the controller and the datapath.
// No dependencies.
package ptst_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int ID_W      = 3;
    localparam int PERIOD_W  = 16;
    localparam int STATUS_W  = 2;

    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_UPDATE = 3'd2;
    localparam logic [2:0] REQ_TICK   = 3'd3;
    localparam logic [2:0] REQ_POLL   = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE = 2'd2;

    typedef struct packed {
        logic [2:0]          req_type;
        logic [ID_W-1:0]     slot_id;
        logic [PERIOD_W-1:0] period;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]     slot_id_res;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_TICK_RD,
        S_TICK_WR,
        S_POLL_RD,
        S_POLL_EX,
        S_POLL_END
    } t_state;

    typedef enum logic [1:0] {
        EMIT_ADDED,
        EMIT_FULL,
        EMIT_MID,
        EMIT_FINAL
    } t_emit;

    typedef struct packed {
        logic  accept;
        logic  do_remove;
        logic  do_update;
        logic  idx_inc;
        logic  rd_en;
        logic  claim;
        logic  tick_wr;
        logic  fire;
        logic  emit_en;
        t_emit emit_kind;
    } t_ctl_cmd;

    typedef struct packed {
        logic at_end;
        logic slot_used;
        logic fires;
        logic pend_vld;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/periodic_timer_slot_table_unit.sv =====
// Top level of the periodic timer slot table.
// Depends on ptst_pkg, ptst_ctrl and ptst_dp.
//
// Requests enter on the input channel (i_valid, o_ready, i_item) and results leave
// on the output channel (o_valid, i_ready, o_item), both valid/ready handshakes.
// Slot 0 is reserved; slots 1 to SLOTS-1 are handed out by add requests.
// Remove and update take effect in the cycle the item is accepted and give no result.
// Add scans one slot per cycle from slot 1 and gives one result. Tick walks the
// slots from slot 1 up to the first free one. Poll walks the same slots and reports
// every expired slot among them in ascending order with last set on the final
// report, or a single report with status none. The slot walk goes through the
// single-port period and count memories; one item is worked on at a time.
// Reset clears all slots and any result held in the output register.
// When the receiver stalls, a finished result waits in the output register; the
// walk pauses at its next report until the register frees, and nothing is lost.
module periodic_timer_slot_table_unit import ptst_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    t_ctl_cmd cmd;
    t_dp_stat stat;

    ptst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_item.req_type),
        .i_stat     (stat),
        .o_ready    (o_ready),
        .o_cmd      (cmd)
    );

    ptst_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_ready (i_ready),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

// ===== rtl/ptst_ctrl.sv =====
// Controller state machine of the periodic timer slot table.
// Depends on ptst_pkg; drives the datapath ptst_dp through t_ctl_cmd.
module ptst_ctrl import ptst_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [2:0] i_req_type,
    input  t_dp_stat   i_stat,
    output logic       o_ready,
    output t_ctl_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_req_type)
                        REQ_ADD:  n_state = S_ADD;
                        REQ_TICK: n_state = S_TICK_RD;
                        REQ_POLL: n_state = S_POLL_RD;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                if ((i_stat.at_end || !i_stat.slot_used) && i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_TICK_RD: begin
                if (i_stat.at_end || !i_stat.slot_used) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_TICK_WR;
                end
            end
            S_TICK_WR: n_state = S_TICK_RD;
            S_POLL_RD: begin
                if (i_stat.at_end || !i_stat.slot_used) begin
                    n_state = S_POLL_END;
                end else begin
                    n_state = S_POLL_EX;
                end
            end
            S_POLL_EX: begin
                if (!i_stat.fires || !i_stat.pend_vld || i_stat.out_free) begin
                    n_state = S_POLL_RD;
                end
            end
            S_POLL_END: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept    = 1'b1;
                    o_cmd.do_remove = (i_req_type == REQ_REMOVE);
                    o_cmd.do_update = (i_req_type == REQ_UPDATE);
                end
            end
            S_ADD: begin
                if (i_stat.at_end) begin
                    o_cmd.emit_en   = i_stat.out_free;
                    o_cmd.emit_kind = EMIT_FULL;
                end else if (i_stat.slot_used) begin
                    o_cmd.idx_inc = 1'b1;
                end else begin
                    o_cmd.claim     = i_stat.out_free;
                    o_cmd.emit_en   = i_stat.out_free;
                    o_cmd.emit_kind = EMIT_ADDED;
                end
            end
            S_TICK_RD: begin
                o_cmd.rd_en = !(i_stat.at_end || !i_stat.slot_used);
            end
            S_TICK_WR: begin
                o_cmd.tick_wr = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            S_POLL_RD: begin
                o_cmd.rd_en = !(i_stat.at_end || !i_stat.slot_used);
            end
            S_POLL_EX: begin
                if (!i_stat.fires) begin
                    o_cmd.idx_inc = 1'b1;
                end else if (!i_stat.pend_vld || i_stat.out_free) begin
                    o_cmd.fire      = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                    o_cmd.emit_en   = i_stat.pend_vld;
                    o_cmd.emit_kind = EMIT_MID;
                end
            end
            S_POLL_END: begin
                o_cmd.emit_en   = i_stat.out_free;
                o_cmd.emit_kind = EMIT_FINAL;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/ptst_dp.sv =====
// Datapath of the periodic timer slot table: valid bits, period and count memories,
// slot index, pending report and output register. Depends on ptst_pkg.
module ptst_dp import ptst_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  logic      i_ready,
    input  t_ctl_cmd  i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_valid,
    output t_out_item o_item
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0]    r_valid;
    logic [PERIOD_W-1:0] mem_period [SLOTS];
    logic [PERIOD_W-1:0] mem_count  [SLOTS];
    logic [PERIOD_W-1:0] r_rd_period;
    logic [PERIOD_W-1:0] r_rd_count;
    logic [PERIOD_W-1:0] r_per;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       r_pend;
    logic                r_pend_vld;
    logic                r_out_vld;
    t_out_item           r_out;

    logic [AW-1:0] idx_a;
    logic [AW-1:0] sid_a;
    logic          sid_ok;
    logic          at_end;

    assign idx_a  = r_idx[AW-1:0];
    assign sid_a  = AW'(i_item.slot_id);
    assign sid_ok = (int'(i_item.slot_id) < SLOTS);
    assign at_end = (r_idx == IW'(SLOTS));

    assign o_stat.at_end    = at_end;
    assign o_stat.slot_used = at_end ? 1'b0 : r_valid[idx_a];
    assign o_stat.fires     = (r_rd_count >= r_rd_period);
    assign o_stat.pend_vld  = r_pend_vld;
    assign o_stat.out_free  = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.do_remove && sid_ok) begin
            r_valid[sid_a] <= 1'b0;
        end else if (i_cmd.claim) begin
            r_valid[idx_a] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_update && sid_ok) begin
            mem_period[sid_a] <= i_item.period;
        end else if (i_cmd.claim) begin
            mem_period[idx_a] <= r_per;
        end
        if (i_cmd.rd_en) begin
            r_rd_period <= mem_period[idx_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.claim || i_cmd.fire) begin
            mem_count[idx_a] <= '0;
        end else if (i_cmd.tick_wr) begin
            mem_count[idx_a] <= r_rd_count + 1'b1;
        end
        if (i_cmd.rd_en) begin
            r_rd_count <= mem_count[idx_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_per <= i_item.period;
            r_idx <= IW'(1);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.fire) begin
            r_pend <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
        end else if (i_cmd.accept) begin
            r_pend_vld <= 1'b0;
        end else if (i_cmd.fire) begin
            r_pend_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit_en) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_en) begin
            case (i_cmd.emit_kind)
                EMIT_ADDED: r_out <= '{slot_id_res: ID_W'(r_idx), status: STAT_OK, last: 1'b1};
                EMIT_FULL:  r_out <= '{slot_id_res: '0, status: STAT_FULL, last: 1'b1};
                EMIT_MID:   r_out <= '{slot_id_res: ID_W'(r_pend), status: STAT_OK, last: 1'b0};
                EMIT_FINAL: begin
                    if (r_pend_vld) begin
                        r_out <= '{slot_id_res: ID_W'(r_pend), status: STAT_OK, last: 1'b1};
                    end else begin
                        r_out <= '{slot_id_res: '0, status: STAT_NONE, last: 1'b1};
                    end
                end
                default: r_out <= r_out;
            endcase
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_out;

endmodule
